FILE: rtl/pcl_pkg.sv
// Package with the word types and command codes of the positional circular list.
`timescale 1ns / 1ps
`default_nettype none
package pcl_pkg;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_AT    = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_AT    = 3'd5,
    MODE_READ_ALL  = 3'd6,
    MODE_NONE      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value_in;
    logic [7:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic               last;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/pcl_store.sv
// Slot store: value and link memories with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module pcl_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          lnk_we_i,
  input  wire logic [AW-1:0] lnk_waddr_i,
  input  wire logic [AW-1:0] lnk_wdata_i,
  input  wire logic          val_we_i,
  input  wire logic [AW-1:0] val_waddr_i,
  input  wire logic [31:0]   val_wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [AW-1:0] lnk_rdata_o,
  output logic      [31:0]   val_rdata_o
);
  logic [AW-1:0] lnk_mem [Depth];
  logic [31:0]   val_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (lnk_we_i) begin
      lnk_mem[lnk_waddr_i] <= lnk_wdata_i;
    end
    lnk_rdata_o <= lnk_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (val_we_i) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    val_rdata_o <= val_mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/positional_circular_list.sv
// Top level of the positional circular list: command sequencer over the slot store.
// Full, empty, range, one-entry delete and unknown mode answer straight from idle; front delete
// and insert into an empty list pass WALK, WAIT and EXEC; other front/back inserts also pass OUT.
// Positional commands walk the list one link per WALK/WAIT pair; delete back walks to the slot
// before the tail; read all reads each slot, then emits its word when the output is free.
// One command in flight; a new word is taken the cycle after its last result word is sent.
// Reset clears the allocation map, head, tail and count at once; no sweep.
`timescale 1ns / 1ps
`default_nettype none
module positional_circular_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pcl_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pcl_pkg::out_word_t     out_word_o
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_WAIT  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_RDOUT = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    mode_q, mode_d;
  logic [31:0]   val_q, val_d;
  logic [CW-1:0] steps_q, steps_d;   // links still to follow
  logic [AW-1:0] cur_q, cur_d;       // slot whose link is being read
  logic [AW-1:0] free_q, free_d;
  logic [CW-1:0] k_q, k_d;
  pcl_pkg::out_word_t res_q, res_d;
  logic          resv_q, resv_d;

  logic          lnk_we, val_we;
  logic [AW-1:0] lnk_wa, lnk_wd, val_wa, raddr, lnk_rd;
  logic [31:0]   val_rd;

  pcl_store #(.Depth(CAPACITY), .AW(AW)) u_store (
    .clk_i, .lnk_we_i(lnk_we), .lnk_waddr_i(lnk_wa), .lnk_wdata_i(lnk_wd),
    .val_we_i(val_we), .val_waddr_i(val_wa), .val_wdata_i(val_q),
    .raddr_i(raddr), .lnk_rdata_o(lnk_rd), .val_rdata_o(val_rd)
  );

  // Lowest free slot, taken when the command is accepted.
  logic [AW-1:0] low_free;
  always_comb begin
    low_free = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) low_free = AW'(i);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !resv_q;
  assign out_valid_o = resv_q;
  assign out_word_o  = res_q;

  pcl_pkg::in_word_t iw;
  logic [7:0] pos_w, cnt_w;
  assign iw    = in_word_i;
  assign pos_w = iw.position;
  assign cnt_w = 8'(cnt_q);

  always_comb begin
    state_d = state_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
    cnt_d = cnt_q; mode_d = mode_q; val_d = val_q; steps_d = steps_q;
    cur_d = cur_q; free_d = free_q; k_d = k_q; res_d = res_q; resv_d = resv_q;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; val_we = 1'b0; val_wa = free_q;
    raddr = cur_q;
    if (resv_q && out_ready_i) resv_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          val_d = iw.value_in; free_d = low_free; cur_d = head_q;
          res_d = '{value_out: '0, status: pcl_pkg::ST_OK, entry_count: 7'(cnt_q),
                    last: 1'b1};
          mode_d = iw.mode; steps_d = '0; k_d = '0;
          case (pcl_pkg::mode_e'(iw.mode))
            pcl_pkg::MODE_INS_FRONT, pcl_pkg::MODE_INS_BACK, pcl_pkg::MODE_INS_AT: begin
              if ({1'b0, cnt_q} >= (CW+1)'(CAPACITY)) begin
                res_d.status = pcl_pkg::ST_FULL; resv_d = 1'b1;
              end else begin
                if (iw.mode == pcl_pkg::MODE_INS_AT) begin
                  if (iw.position <= 8'd1) mode_d = pcl_pkg::MODE_INS_FRONT;
                  else if (pos_w >= cnt_w) mode_d = pcl_pkg::MODE_INS_BACK;
                  else steps_d = CW'(pos_w - 2);
                end
                state_d = S_WALK;
              end
            end
            pcl_pkg::MODE_DEL_FRONT, pcl_pkg::MODE_DEL_BACK, pcl_pkg::MODE_DEL_AT: begin
              if (cnt_q == '0 && !(iw.mode == pcl_pkg::MODE_DEL_AT && iw.position > 8'd1))
              begin
                res_d.status = pcl_pkg::ST_EMPTY; resv_d = 1'b1;
              end else if (iw.mode == pcl_pkg::MODE_DEL_AT && iw.position > 8'd1
                           && pos_w > cnt_w) begin
                res_d.status = pcl_pkg::ST_RANGE; resv_d = 1'b1;
              end else if (cnt_q == CW'(1)) begin
                used_d[head_q] = 1'b0; head_d = '0; tail_d = '0; cnt_d = '0;
                res_d.entry_count = '0; resv_d = 1'b1;
              end else begin
                if (iw.mode == pcl_pkg::MODE_DEL_AT) begin
                  if (iw.position <= 8'd1) mode_d = pcl_pkg::MODE_DEL_FRONT;
                  else if (pos_w == cnt_w) mode_d = pcl_pkg::MODE_DEL_BACK;
                  else steps_d = CW'(pos_w - 2);
                end
                if (mode_d == pcl_pkg::MODE_DEL_BACK) steps_d = cnt_q - CW'(2);
                state_d = S_WALK;
              end
            end
            pcl_pkg::MODE_READ_ALL: begin
              if (cnt_q == '0) begin
                res_d.status = pcl_pkg::ST_EMPTY; resv_d = 1'b1;
              end else state_d = S_RDOUT;
            end
            default: resv_d = 1'b1;
          endcase
        end
      end
      // Issue a read of cur; the following state sees its link.
      S_WALK: begin
        raddr = cur_q; state_d = S_WAIT;
      end
      S_WAIT: begin
        if (steps_q != '0) begin
          cur_d = lnk_rd; steps_d = steps_q - CW'(1); state_d = S_WALK;
        end else state_d = S_EXEC;
      end
      // lnk_rd still holds link of cur (prev slot) here.
      S_EXEC: begin
        state_d = S_IDLE; resv_d = 1'b1;
        case (pcl_pkg::mode_e'(mode_q))
          pcl_pkg::MODE_INS_FRONT, pcl_pkg::MODE_INS_BACK: begin
            val_we = 1'b1; used_d[free_q] = 1'b1; cnt_d = cnt_q + CW'(1);
            // Two link writes when the list is not empty: new slot, then tail; done in EXEC and OUT.
            lnk_we = 1'b1; lnk_wa = free_q;
            lnk_wd = (cnt_q == '0) ? free_q : head_q;
            if (cnt_q == '0) begin
              head_d = free_q; tail_d = free_q; resv_d = 1'b1;
            end else begin
              state_d = S_OUT; resv_d = 1'b0;
              if (mode_q == pcl_pkg::MODE_INS_FRONT) head_d = free_q;
              else tail_d = free_q;
            end
            res_d.entry_count = 7'(cnt_q + CW'(1));
          end
          pcl_pkg::MODE_INS_AT: begin
            val_we = 1'b1; used_d[free_q] = 1'b1; cnt_d = cnt_q + CW'(1);
            lnk_we = 1'b1; lnk_wa = free_q; lnk_wd = lnk_rd;
            res_d.entry_count = 7'(cnt_q + CW'(1));
            state_d = S_OUT; resv_d = 1'b0;
          end
          pcl_pkg::MODE_DEL_FRONT: begin
            used_d[head_q] = 1'b0; head_d = lnk_rd; cnt_d = cnt_q - CW'(1);
            lnk_we = 1'b1; lnk_wa = tail_q; lnk_wd = lnk_rd;
            res_d.entry_count = 7'(cnt_q - CW'(1));
          end
          pcl_pkg::MODE_DEL_BACK: begin
            used_d[tail_q] = 1'b0; tail_d = cur_q; cnt_d = cnt_q - CW'(1);
            lnk_we = 1'b1; lnk_wa = cur_q; lnk_wd = head_q;
            res_d.entry_count = 7'(cnt_q - CW'(1));
          end
          default: begin
            // Delete at: read the target's link next.
            free_d = lnk_rd; raddr = lnk_rd; state_d = S_OUT; resv_d = 1'b0;
          end
        endcase
      end
      // Second write of a command.
      S_OUT: begin
        state_d = S_IDLE; resv_d = 1'b1; lnk_we = 1'b1;
        case (pcl_pkg::mode_e'(mode_q))
          pcl_pkg::MODE_INS_AT: begin
            lnk_wa = cur_q; lnk_wd = free_q;
          end
          pcl_pkg::MODE_DEL_AT: begin
            lnk_wa = cur_q; lnk_wd = lnk_rd; used_d[free_q] = 1'b0;
            cnt_d = cnt_q - CW'(1); res_d.entry_count = 7'(cnt_q - CW'(1));
          end
          default: begin
            // Tail links to the newly placed slot.
            lnk_wa = tail_q; lnk_wd = free_q;
            if (mode_q == pcl_pkg::MODE_INS_BACK) lnk_wa = cur_q;
          end
        endcase
      end
      // Read all: read the slot, then emit it, each step only when the output is free.
      S_RDOUT: begin
        if (!resv_q || out_ready_i) begin
          if (steps_q == '0) begin
            raddr = cur_q; steps_d = CW'(1);
          end else begin
            res_d = '{value_out: val_rd, status: pcl_pkg::ST_OK,
                      entry_count: 7'(cnt_q), last: (k_q + CW'(1) == cnt_q)};
            resv_d = 1'b1; cur_d = lnk_rd; steps_d = '0; k_d = k_q + CW'(1);
            if (k_q + CW'(1) == cnt_q) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // In insert back, cur still holds the old tail's slot at OUT.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; head_q <= '0; tail_q <= '0;
      cnt_q <= '0; resv_q <= 1'b0; steps_q <= '0; k_q <= '0;
    end else begin
      state_q <= state_d; used_q <= used_d; head_q <= head_d; tail_q <= tail_d;
      cnt_q <= cnt_d; resv_q <= resv_d; steps_q <= steps_d; k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; val_q <= val_d; free_q <= free_d; res_q <= res_d;
    cur_q  <= (state_q == S_IDLE && in_valid_i && in_ready_o
               && mode_d == pcl_pkg::MODE_INS_BACK) ? tail_q :
              (state_q == S_IDLE && in_valid_i && in_ready_o) ? head_q : cur_d;
  end
endmodule
`default_nettype wire

FILE: rtl/pcl_checker.sv
// Port-level checker for the positional circular list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pcl_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire pcl_pkg::out_word_t out_word_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.entry_count <= 7'd64)
    else $error("entry count out of range");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == pcl_pkg::ST_EMPTY |->
      out_word_o.last && out_word_o.value_out == 32'sd0)
    else $error("empty status word malformed");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while result pending");
endmodule

bind positional_circular_list pcl_checker u_pcl_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_word_o
);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench of the positional circular list with its own list predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CAP = 64;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pcl_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pcl_pkg::out_word_t out_word;

  // Predicted list: values kept in order, front first.
  logic signed [31:0] list_q[$];
  pcl_pkg::out_word_t pending_q[$];
  int unsigned        fail_count = 0;
  bit                 gaps_on = 1'b1;
  bit                 hold_rx = 1'b0;

  always #5 clk = ~clk;

  positional_circular_list #(.CAPACITY(CAP)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word)
  );

  task automatic report_mismatch(input string what, input pcl_pkg::out_word_t got,
                                 input pcl_pkg::out_word_t exp);
    $display("mismatch %s: got v=%0d st=%0d n=%0d l=%0b exp v=%0d st=%0d n=%0d l=%0b", what,
             got.value_out, got.status, got.entry_count, got.last,
             exp.value_out, exp.status, exp.entry_count, exp.last);
    fail_count++;
  endtask

  function automatic pcl_pkg::out_word_t single_word(input pcl_pkg::status_e st);
    pcl_pkg::out_word_t w;
    w.value_out = '0;
    w.status = st;
    w.entry_count = 7'(list_q.size());
    w.last = 1'b1;
    return w;
  endfunction

  // Advances the predicted list by one command and queues its result words.
  task automatic predict_command(input pcl_pkg::in_word_t cmd);
    int n;
    pcl_pkg::out_word_t w;
    n = list_q.size();
    case (pcl_pkg::mode_e'(cmd.mode))
      pcl_pkg::MODE_INS_FRONT, pcl_pkg::MODE_INS_BACK, pcl_pkg::MODE_INS_AT: begin
        if (n >= CAP) begin
          pending_q.push_back(single_word(pcl_pkg::ST_FULL));
        end else begin
          if (cmd.mode == pcl_pkg::MODE_INS_FRONT ||
              (cmd.mode == pcl_pkg::MODE_INS_AT && cmd.position <= 1))
            list_q.push_front(cmd.value_in);
          else if (cmd.mode == pcl_pkg::MODE_INS_BACK || cmd.position >= n)
            list_q.push_back(cmd.value_in);
          else
            list_q.insert(cmd.position - 1, cmd.value_in);
          pending_q.push_back(single_word(pcl_pkg::ST_OK));
        end
      end
      pcl_pkg::MODE_DEL_FRONT, pcl_pkg::MODE_DEL_BACK, pcl_pkg::MODE_DEL_AT: begin
        if (cmd.mode == pcl_pkg::MODE_DEL_AT && cmd.position > 1 && cmd.position > n) begin
          pending_q.push_back(single_word(pcl_pkg::ST_RANGE));
        end else if (n == 0) begin
          pending_q.push_back(single_word(pcl_pkg::ST_EMPTY));
        end else begin
          if (cmd.mode == pcl_pkg::MODE_DEL_FRONT ||
              (cmd.mode == pcl_pkg::MODE_DEL_AT && cmd.position <= 1))
            void'(list_q.pop_front());
          else if (cmd.mode == pcl_pkg::MODE_DEL_BACK)
            void'(list_q.pop_back());
          else
            list_q.delete(cmd.position - 1);
          pending_q.push_back(single_word(pcl_pkg::ST_OK));
        end
      end
      pcl_pkg::MODE_READ_ALL: begin
        if (n == 0) begin
          pending_q.push_back(single_word(pcl_pkg::ST_EMPTY));
        end else begin
          for (int k = 0; k < n; k++) begin
            w.value_out = list_q[k];
            w.status = pcl_pkg::ST_OK;
            w.entry_count = 7'(n);
            w.last = (k == n - 1);
            pending_q.push_back(w);
          end
        end
      end
      default: pending_q.push_back(single_word(pcl_pkg::ST_OK));
    endcase
  endtask

  // Valid stays high after acceptance until the next word or an idle gap replaces it.
  task automatic send_word(input pcl_pkg::mode_e m, input logic signed [31:0] v,
                           input logic [7:0] p);
    pcl_pkg::in_word_t cmd;
    cmd.mode = m;
    cmd.value_in = v;
    cmd.position = p;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(cmd);
  endtask

  // Receiver: random stalls, or a long hold while hold_rx is set.
  always @(posedge clk) begin
    if (hold_rx) out_ready <= 1'b0;
    else if (gaps_on && $urandom_range(0, 3) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", out_word, '0);
      end else begin
        if (out_word !== pending_q[0]) report_mismatch("field", out_word, pending_q[0]);
        void'(pending_q.pop_front());
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(pcl_pkg::MODE_DEL_FRONT, 0, 0);
    send_word(pcl_pkg::MODE_DEL_BACK, 0, 0);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 1);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 0);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 8'hff);
    send_word(pcl_pkg::MODE_READ_ALL, 0, 0);
    send_word(pcl_pkg::MODE_INS_FRONT, 32'sh7fffffff, 0);
    send_word(pcl_pkg::MODE_INS_BACK, 32'sh80000000, 0);
    send_word(pcl_pkg::MODE_INS_AT, 32'sd5, 0);
    send_word(pcl_pkg::MODE_INS_AT, 32'sd6, 1);
    send_word(pcl_pkg::MODE_INS_AT, -32'sd1, 4);
    send_word(pcl_pkg::MODE_INS_AT, 32'sd7, 8'hff);
    send_word(pcl_pkg::MODE_INS_AT, 32'sd8, 3);
    send_word(pcl_pkg::MODE_READ_ALL, 0, 0);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 7);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 8);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 3);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 1);
    send_word(pcl_pkg::MODE_DEL_BACK, 0, 0);
    send_word(pcl_pkg::MODE_NONE, 32'sh5a5a5a5a, 8'haa);
    send_word(pcl_pkg::MODE_READ_ALL, 0, 0);
  endtask

  // Fills the list to capacity, tries inserts into the full list, reads it out, and drains it again.
  task automatic test_full();
    while (list_q.size() < CAP) send_word(pcl_pkg::mode_e'($urandom_range(0, 2)),
                                          rand_value(), 8'($urandom_range(0, 70)));
    send_word(pcl_pkg::MODE_INS_FRONT, 1, 0);
    send_word(pcl_pkg::MODE_INS_BACK, 2, 0);
    send_word(pcl_pkg::MODE_INS_AT, 3, 9);
    send_word(pcl_pkg::MODE_READ_ALL, 0, 0);
    send_word(pcl_pkg::MODE_DEL_AT, 0, 8'(CAP));
    send_word(pcl_pkg::MODE_DEL_AT, 0, 8'(CAP));
    while (list_q.size() > 0) send_word(pcl_pkg::mode_e'($urandom_range(3, 5)), 0,
                                        8'($urandom_range(0, list_q.size() + 1)));
  endtask

  // Receiver holds off for a long stretch while read-all commands wait on it.
  task automatic test_backpressure();
    repeat (8) send_word(pcl_pkg::MODE_INS_BACK, rand_value(), 0);
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      repeat (4) send_word(pcl_pkg::MODE_READ_ALL, 0, 0);
    join
  endtask

  task automatic test_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_word(pcl_pkg::mode_e'($urandom_range(0, 2)), rand_value(),
                  8'(list_q.size() < 40 || $urandom_range(0, 9) == 0 ?
                     $urandom_range(0, 255) : $urandom_range(0, list_q.size() + 1)));
      else if (r < 85)
        send_word(pcl_pkg::mode_e'($urandom_range(3, 5)), rand_value(),
                  8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
                     $urandom_range(0, list_q.size() + 1)));
      else if (r < 95)
        send_word(pcl_pkg::MODE_READ_ALL, rand_value(), 8'($urandom));
      else
        send_word(pcl_pkg::MODE_NONE, rand_value(), 8'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full();
    test_backpressure();
    test_random(220);
    gaps_on = 1'b0;
    test_random(100);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("positional_circular_list regression: pass");
    else $display("positional_circular_list regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("positional_circular_list regression: fail");
    $finish;
  end
endmodule

FILE: positional_circular_list.f
rtl/pcl_pkg.sv
rtl/pcl_store.sv
rtl/positional_circular_list.sv
rtl/pcl_checker.sv
dv/tb_top.sv
